@@ src/esc_pkg.sv @@
// Shared types, constants and calendar helper functions for the epoch-to-calendar block.
package esc_pkg;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned STEP_W        = 5;
  localparam logic [7:0]  BASE_YEAR     = 8'd70;
  // 1970-01-01 was a Thursday.
  localparam logic [2:0]  BASE_WEEKDAY  = 3'd4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 5'd0;
  localparam step_t STEP_YEAR  = 5'd1;
  localparam step_t STEP_MONTH = 5'd2;
  localparam step_t STEP_DIV   = 5'd3;
  localparam step_t STEP_DONE  = 5'd19;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DIV,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    DST_DAY,
    DST_HOUR,
    DST_MIN
  } dst_t;

  typedef struct packed {
    op_t        op;
    dst_t       dst;
    logic [2:0] sh;
    step_t      jmp_true;
    step_t      jmp_false;
  } ctrl_t;

  typedef struct packed {
    logic year_ge;
    logic month_ge;
  } stat_t;

  typedef struct packed {
    logic start;
    logic deliver;
  } seq_t;

  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
    logic       clamped;
  } res_t;

  // Year relative to 1900; within 70..255 only 2100 is a century year that is not leap.
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != 8'd200);
  endfunction

  function automatic logic [31:0] year_secs(input logic leap);
    return leap ? 32'(366 * SECS_PER_DAY) : 32'(365 * SECS_PER_DAY);
  endfunction

  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] s;
    case (m)
      4'd1:                    s = leap ? 32'(29 * SECS_PER_DAY) : 32'(28 * SECS_PER_DAY);
      4'd3, 4'd5, 4'd8, 4'd10: s = 32'(30 * SECS_PER_DAY);
      default:                 s = 32'(31 * SECS_PER_DAY);
    endcase
    return s;
  endfunction

  // Length of the month modulo 7, used to advance the weekday.
  function automatic logic [2:0] month_wd_inc(input logic [3:0] m, input logic leap);
    logic [2:0] w;
    case (m)
      4'd1:                    w = leap ? 3'd1 : 3'd0;
      4'd3, 4'd5, 4'd8, 4'd10: w = 3'd2;
      default:                 w = 3'd3;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] pow2_mod7(input logic [2:0] sh);
    logic [2:0] w;
    case (sh)
      3'd0, 3'd3, 3'd6: w = 3'd1;
      3'd1, 3'd4, 3'd7: w = 3'd2;
      default:          w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [2:0] inc);
    logic [3:0] s;
    s = {1'b0, w} + {1'b0, inc};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  function automatic logic [31:0] div_const(input dst_t dst, input logic [2:0] sh);
    logic [31:0] base;
    case (dst)
      DST_DAY:  base = 32'(SECS_PER_DAY);
      DST_HOUR: base = 32'(SECS_PER_HOUR);
      default:  base = 32'(SECS_PER_MIN);
    endcase
    return base << sh;
  endfunction

endpackage

@@ src/esc_if.sv @@
// Valid/ready channel interfaces for the timestamp input and the calendar result.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] years_since_1900;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;
  logic [2:0] weekday;
  logic       clamped;

  modport source (output valid, output years_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output weekday, output clamped, input ready);
  modport sink   (input valid, input years_since_1900, input month_index,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, input weekday, input clamped, output ready);
endinterface

@@ src/esc_ucode_rom.sv @@
// Microcode program store: one control word per sequencer step.
module esc_ucode_rom (
  input  esc_pkg::step_t step,
  output esc_pkg::ctrl_t ctrl
);
  import esc_pkg::*;

  function automatic ctrl_t div_word(input dst_t dst, input logic [2:0] sh, input step_t nxt);
    return '{op: OP_DIV, dst: dst, sh: sh, jmp_true: nxt, jmp_false: nxt};
  endfunction

  always_comb begin
    unique case (step)
      STEP_IDLE:  ctrl = '{op: OP_LOAD, dst: DST_DAY, sh: 3'd0,
                          jmp_true: STEP_YEAR, jmp_false: STEP_IDLE};
      STEP_YEAR:  ctrl = '{op: OP_YEAR, dst: DST_DAY, sh: 3'd0,
                          jmp_true: STEP_YEAR, jmp_false: STEP_MONTH};
      STEP_MONTH: ctrl = '{op: OP_MONTH, dst: DST_DAY, sh: 3'd0,
                          jmp_true: STEP_MONTH, jmp_false: STEP_DIV};
      // Day of month: restoring division by 86400, quotient bits 4 down to 0.
      5'd3:  ctrl = div_word(DST_DAY, 3'd4, 5'd4);
      5'd4:  ctrl = div_word(DST_DAY, 3'd3, 5'd5);
      5'd5:  ctrl = div_word(DST_DAY, 3'd2, 5'd6);
      5'd6:  ctrl = div_word(DST_DAY, 3'd1, 5'd7);
      5'd7:  ctrl = div_word(DST_DAY, 3'd0, 5'd8);
      // Hour: division by 3600.
      5'd8:  ctrl = div_word(DST_HOUR, 3'd4, 5'd9);
      5'd9:  ctrl = div_word(DST_HOUR, 3'd3, 5'd10);
      5'd10: ctrl = div_word(DST_HOUR, 3'd2, 5'd11);
      5'd11: ctrl = div_word(DST_HOUR, 3'd1, 5'd12);
      5'd12: ctrl = div_word(DST_HOUR, 3'd0, 5'd13);
      // Minute: division by 60; what remains is the second.
      5'd13: ctrl = div_word(DST_MIN, 3'd5, 5'd14);
      5'd14: ctrl = div_word(DST_MIN, 3'd4, 5'd15);
      5'd15: ctrl = div_word(DST_MIN, 3'd3, 5'd16);
      5'd16: ctrl = div_word(DST_MIN, 3'd2, 5'd17);
      5'd17: ctrl = div_word(DST_MIN, 3'd1, 5'd18);
      5'd18: ctrl = div_word(DST_MIN, 3'd0, STEP_DONE);
      STEP_DONE: ctrl = '{op: OP_DONE, dst: DST_DAY, sh: 3'd0,
                          jmp_true: STEP_IDLE, jmp_false: STEP_DONE};
      default:   ctrl = '{op: OP_LOAD, dst: DST_DAY, sh: 3'd0,
                          jmp_true: STEP_IDLE, jmp_false: STEP_IDLE};
    endcase
  end

endmodule

@@ src/esc_datapath.sv @@
// Datapath: remaining-seconds register, year/month walk, constant division steps.
module esc_datapath (
  input  logic                clk,
  input  esc_pkg::ctrl_t      ctrl,
  input  esc_pkg::seq_t       seq,
  input  logic [31:0]         epoch_seconds,
  input  logic signed [16:0]  zone_offset_seconds,
  output esc_pkg::stat_t      stat,
  output esc_pkg::res_t       res
);
  import esc_pkg::*;

  logic [31:0] t;
  logic [7:0]  year;
  logic [3:0]  month;
  logic [2:0]  wd;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic        clamped;

  logic        leap;
  logic [31:0] ysecs;
  logic [31:0] msecs;
  logic [31:0] dconst;
  logic        div_ge;
  logic [33:0] sum;

  assign leap   = is_leap(year);
  assign ysecs  = year_secs(leap);
  assign msecs  = month_secs(month, leap);
  assign dconst = div_const(ctrl.dst, ctrl.sh);
  assign div_ge = (t >= dconst);
  assign sum    = {2'b00, epoch_seconds} + {{17{zone_offset_seconds[16]}}, zone_offset_seconds};

  assign stat.year_ge  = (t >= ysecs);
  assign stat.month_ge = (month < 4'd11) && (t >= msecs);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (seq.start) begin
          // Negative sums saturate at zero, overflowing sums at the top of the range.
          if (sum[33]) begin
            t       <= 32'd0;
            clamped <= 1'b1;
          end else if (sum[32]) begin
            t       <= 32'hFFFF_FFFF;
            clamped <= 1'b1;
          end else begin
            t       <= sum[31:0];
            clamped <= 1'b0;
          end
          year   <= BASE_YEAR;
          month  <= 4'd0;
          wd     <= BASE_WEEKDAY;
          day_q  <= 5'd0;
          hour_q <= 5'd0;
          min_q  <= 6'd0;
        end
      end
      OP_YEAR: begin
        if (stat.year_ge) begin
          t    <= t - ysecs;
          year <= year + 8'd1;
          wd   <= wd_add(wd, leap ? 3'd2 : 3'd1);
        end
      end
      OP_MONTH: begin
        if (stat.month_ge) begin
          t     <= t - msecs;
          month <= month + 4'd1;
          wd    <= wd_add(wd, month_wd_inc(month, leap));
        end
      end
      OP_DIV: begin
        if (div_ge) begin
          t <= t - dconst;
          case (ctrl.dst)
            DST_DAY: begin
              day_q <= day_q | (5'd1 << ctrl.sh);
              wd    <= wd_add(wd, pow2_mod7(ctrl.sh));
            end
            DST_HOUR: hour_q <= hour_q | (5'd1 << ctrl.sh);
            default:  min_q  <= min_q | (6'd1 << ctrl.sh);
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.years_since_1900 = year;
    res.month_index      = month;
    res.day_of_month     = day_q + 5'd1;
    res.hour_of_day      = hour_q;
    res.minute_of_hour   = min_q;
    res.second_of_minute = t[5:0];
    res.weekday          = wd;
    res.clamped          = clamped;
  end

endmodule

@@ src/esc_sequencer.sv @@
// Step counter with conditional jumps, driven by the microcode store.
module esc_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           slot_free,
  input  esc_pkg::stat_t stat,
  output esc_pkg::ctrl_t ctrl,
  output esc_pkg::seq_t  seq,
  output logic           in_ready
);
  import esc_pkg::*;

  step_t step;
  step_t step_next;
  logic  cond;

  esc_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.op)
      OP_LOAD:  cond = in_valid;
      OP_YEAR:  cond = stat.year_ge;
      OP_MONTH: cond = stat.month_ge;
      OP_DONE:  cond = slot_free;
      default:  cond = 1'b1;
    endcase
    step_next = cond ? ctrl.jmp_true : ctrl.jmp_false;
  end

  assign in_ready    = (ctrl.op == OP_LOAD);
  assign seq.start   = in_ready && in_valid;
  assign seq.deliver = (ctrl.op == OP_DONE) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ src/epoch_seconds_to_calendar.sv @@
// Top level of the epoch-seconds to calendar converter: channels, register port, result slot.
//
// Usage: a 32-bit unsigned Unix timestamp arrives as one word on in_ch. The
// programmed signed time-zone offset (register 0, byte address 0) is added,
// the sum is saturated to 0..2^32-1 with the clamped flag raised when that
// happens, and one result word leaves on out_ch with the year since 1900,
// month, day of month, hour, minute, second and weekday.
//
// Timing: one word at a time. The microcode sequencer loads the word, walks the
// elapsed years and then the elapsed months, runs the restoring division steps by
// 86400, 3600 and 60, and hands the result to the output register. The year walk
// is the longest part; a word in December 2105 takes longest.
//
// The result sits in an output register, so the next word is accepted while
// a finished result still waits. If the receiver stalls, the sequencer holds
// in its final step until the register frees up, and in_ch stays not ready.
// Synchronous reset returns the sequencer to its idle step, empties the
// output register and clears the offset to zero.
module epoch_seconds_to_calendar (
  input  logic             clk,
  input  logic             rst,
  esc_in_if.sink           in_ch,
  esc_out_if.source        out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import esc_pkg::*;

  localparam logic REG_ZONE_OFFSET = 1'b0;

  logic signed [16:0] zone_offset_seconds;
  logic               cfg_write;

  ctrl_t ctrl;
  seq_t  seq;
  stat_t stat;
  res_t  res;
  res_t  out_res;
  logic  out_valid;
  logic  slot_free;
  logic  in_ready;

  // Register port. Only bit 2 of the address selects a register; a write
  // beyond the single register lands nowhere.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= 17'sd0;
    end else if (cfg_write && (paddr[2] == REG_ZONE_OFFSET)) begin
      zone_offset_seconds <= pwdata[16:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ZONE_OFFSET) begin
      prdata = {{15{zone_offset_seconds[16]}}, zone_offset_seconds};
    end else begin
      prdata = 32'd0;
    end
  end

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !out_valid || out_ch.ready;

  esc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .slot_free (slot_free),
    .stat      (stat),
    .ctrl      (ctrl),
    .seq       (seq),
    .in_ready  (in_ready)
  );

  esc_datapath u_dp (
    .clk                 (clk),
    .ctrl                (ctrl),
    .seq                 (seq),
    .epoch_seconds       (in_ch.epoch_seconds),
    .zone_offset_seconds (zone_offset_seconds),
    .stat                (stat),
    .res                 (res)
  );

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.deliver) begin
      out_res <= res;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.years_since_1900 = out_res.years_since_1900;
  assign out_ch.month_index      = out_res.month_index;
  assign out_ch.day_of_month     = out_res.day_of_month;
  assign out_ch.hour_of_day      = out_res.hour_of_day;
  assign out_ch.minute_of_hour   = out_res.minute_of_hour;
  assign out_ch.second_of_minute = out_res.second_of_minute;
  assign out_ch.weekday          = out_res.weekday;
  assign out_ch.clamped          = out_res.clamped;

endmodule

@@ verif/esc_checker.sv @@
// Scoreboard for the epoch-to-calendar block: predicts each result word and compares it.
module esc_checker #(
  parameter logic [2:0] ZONE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  esc_in_if           in_ch,
  esc_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned clamped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam longint      EPOCH_MAX       = 64'd4294967295;
  localparam int unsigned MAX_PRINTED     = 100;

  logic signed [16:0] zone;
  res_t               calendar_due [$];

  // Years are counted from 1900, so a year divisible by 400 leaves 100.
  function automatic bit leap_since_1900(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 100));
  endfunction

  function automatic res_t break_down_timestamp(input logic [31:0] epoch,
                                                input logic signed [16:0] offset);
    res_t             r;
    longint           sum;
    longint unsigned  t;
    longint unsigned  span;
    int unsigned      yr;
    int unsigned      mon;
    int unsigned      mlen;
    sum = longint'(epoch) + longint'(offset);
    r.clamped = 1'b0;
    if (sum < 0) begin
      sum = 0;
      r.clamped = 1'b1;
    end else if (sum > EPOCH_MAX) begin
      sum = EPOCH_MAX;
      r.clamped = 1'b1;
    end
    t = longint'(sum);
    r.weekday = 3'((t / SECS_PER_DAY + 4) % 7);
    yr = 70;
    span = 365 * SECS_PER_DAY;
    while (t >= span) begin
      t -= span;
      yr++;
      span = (leap_since_1900(yr) ? 366 : 365) * SECS_PER_DAY;
    end
    mon = 0;
    while (mon < 11) begin
      mlen = MONTH_DAYS[mon];
      if (mon == 1 && leap_since_1900(yr)) begin
        mlen = 29;
      end
      if (t < mlen * SECS_PER_DAY) begin
        break;
      end
      t -= mlen * SECS_PER_DAY;
      mon++;
    end
    r.second_of_minute = 6'(t % 60);
    t = t / 60;
    r.minute_of_hour = 6'(t % 60);
    t = t / 60;
    r.hour_of_day = 5'(t % 24);
    t = t / 24;
    r.day_of_month = 5'(t + 1);
    r.years_since_1900 = 8'(yr);
    r.month_index = 4'(mon);
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      log_mismatch($sformatf("result word %0d, %s is %0d, predicted %0d",
                             results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      zone <= '0;
      calendar_due.delete();
    end else begin
      // A result word is checked before the same edge's input word is queued.
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.years_since_1900, out_ch.month_index, out_ch.day_of_month,
               out_ch.hour_of_day, out_ch.minute_of_hour, out_ch.second_of_minute,
               out_ch.weekday, out_ch.clamped};
        if (calendar_due.size() == 0) begin
          log_mismatch($sformatf("result word %0d arrived with nothing predicted",
                                 results_seen));
        end else begin
          want = calendar_due.pop_front();
          compare_field("years_since_1900", got.years_since_1900, want.years_since_1900);
          compare_field("month_index", got.month_index, want.month_index);
          compare_field("day_of_month", got.day_of_month, want.day_of_month);
          compare_field("hour_of_day", got.hour_of_day, want.hour_of_day);
          compare_field("minute_of_hour", got.minute_of_hour, want.minute_of_hour);
          compare_field("second_of_minute", got.second_of_minute, want.second_of_minute);
          compare_field("weekday", got.weekday, want.weekday);
          compare_field("clamped", got.clamped, want.clamped);
        end
        results_seen++;
        if (got.clamped) begin
          clamped_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        calendar_due.push_back(break_down_timestamp(in_ch.epoch_seconds, zone));
      end
      if (psel && penable && pwrite && pready && paddr == ZONE_ADDR) begin
        zone <= pwdata[16:0];
      end
    end
    pending <= calendar_due.size();
  end

endmodule

@@ verif/epoch_seconds_to_calendar_tb.sv @@
// Testbench top for the epoch-to-calendar block: stimulus, register writes and verdict.
module epoch_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: the offset sits at index 0; index 1 is past the list and must be ignored.
  localparam logic [2:0]  ZONE_OFFSET_ADDR   = 3'd0;
  localparam logic [2:0]  SPARE_ADDR         = 3'd4;
  // The quiet period after the last prediction is longer than the block needs for any one word.
  localparam int unsigned DRAIN_CYCLES       = 200;
  localparam int unsigned LIMIT_CYCLES       = 2000000;
  localparam int unsigned RANDOM_PER_SETTING = 125;
  localparam int unsigned SETTING_COUNT      = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned clamped_seen;
  int unsigned words_sent;
  int unsigned settings_used;
  int unsigned cycle_count;
  int unsigned stall_mode;
  int unsigned mode_left;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  epoch_seconds_to_calendar dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  esc_checker #(.ZONE_ADDR(ZONE_OFFSET_ADDR)) scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .clamped_seen (clamped_seen)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Guard against a hang: a correct run finishes well inside this many cycles.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timed out after %0d cycles with %0d result words outstanding.",
             cycle_count, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The result side stalls on its own schedule. Whenever its mode counter runs out it picks
  // a new mode: always ready, coin flip, mostly stalled, or long stalls with rare single-cycle
  // openings. The always-ready mode gives stretches with no backpressure at all.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ch.ready <= (mode_left % 37 == 0);
      end
    endcase
  end

  // Waits until the scoreboard holds no prediction, then lets the block go quiet. The
  // first edge lets the pending count catch up with a word accepted at the current edge.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes when pready
  // is high. Called right after a rising edge.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Changes the offset with the block idle. The bits above the 17-bit field carry noise,
  // and a write to the unmapped index follows so that its being ignored is checked too.
  task automatic write_zone(input logic [16:0] zone);
    logic [31:0] data;
    data = $urandom;
    data[16:0] = zone;
    settle();
    write_reg(ZONE_OFFSET_ADDR, data);
    write_reg(SPARE_ADDR, $urandom);
    settings_used++;
  endtask

  // Sends words in bursts of random length. Between bursts the valid line drops for a
  // random gap, which is sometimes zero so that bursts run back to back. Valid is only
  // lowered when a gap really follows, so it never drops and rises in one time step.
  task automatic push_words(input logic [31:0] words [$]);
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    idx = 0;
    while (idx < words.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < words.size()) begin
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= words[idx];
        @(posedge clk);
        while (!in_ch.ready) begin
          @(posedge clk);
        end
        idx++;
        burst--;
        words_sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          gap = 0;
        end
        9: begin
          gap = $urandom_range(20, 200);
        end
        default: begin
          gap = $urandom_range(1, 8);
        end
      endcase
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] batch [$];
    logic [16:0] phase_zones [SETTING_COUNT];
    logic [31:0] w;
    longint      at;
    int unsigned yr;
    int unsigned days;

    // Every input driven from here starts at a known value; the ready line is set by
    // the stall pattern from the first edge on, while reset is still high.
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.epoch_seconds <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words with no offset: the first and last seconds of minutes, days and
    // years, the leap day of 1972, the leap day of 2000 (a century year that is leap),
    // the end of February 2100 (a century year that is not), the two halves of the
    // range, alternating bit patterns and the top of the range.
    write_zone(17'h00000);
    batch = '{32'd0, 32'd1, 32'd60, 32'd3599, 32'd86399, 32'd86400,
              32'd31535999, 32'd31536000, 32'd68169600, 32'd946684799,
              32'd951782400, 32'd978220799, 32'd4107456000, 32'd4107542400,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hFFFF_FFFE, 32'hFFFF_FFFF};
    push_words(batch);

    // Lowest offset: a sum below zero clamps to the start of 1970, one second later
    // it lands exactly on zero without clamping.
    write_zone(17'(-50400));
    batch = '{32'd0, 32'd50399, 32'd50400};
    push_words(batch);

    // Highest offset: the sum just reaches the top of the range, then goes past it.
    write_zone(17'(54000));
    batch = '{32'hFFFF_FFFF - 32'd54000, 32'hFFFF_FFFF - 32'd53999, 32'hFFFF_FFFF};
    push_words(batch);

    // Random part, one batch per offset setting. The settings include both ends of the
    // stated range and both ends of what 17 bits can hold.
    phase_zones[0] = 17'h00000;
    phase_zones[1] = 17'(-50400);
    phase_zones[2] = 17'(54000);
    phase_zones[3] = 17'h10000;
    phase_zones[4] = 17'h0FFFF;
    phase_zones[5] = 17'($urandom_range(0, 104400) - 50400);
    phase_zones[6] = 17'($urandom);
    phase_zones[7] = 17'($urandom_range(0, 104400) - 50400);

    for (int p = 0; p < SETTING_COUNT; p++) begin
      write_zone(phase_zones[p]);
      batch.delete();
      for (int k = 0; k < RANDOM_PER_SETTING; k++) begin
        case ($urandom_range(0, 9))
          5: begin
            w = $urandom_range(0, 200000);
          end
          6: begin
            w = 32'hFFFF_FFFF - $urandom_range(0, 200000);
          end
          7, 8, 9: begin
            // Land within a day of a new year or of the end of February, where the
            // year and month walks turn over. Between 1970 and 2105 the century year
            // 2000 is leap and 2100 is not.
            yr = $urandom_range(70, 205);
            days = 0;
            for (int yy = 70; yy < yr; yy++) begin
              days += (yy % 4 == 0 && yy != 200) ? 366 : 365;
            end
            case ($urandom_range(0, 3))
              0: days += 0;
              1: days += 58;
              2: days += 59;
              default: days += 60;
            endcase
            at = longint'(days) * 86400 + longint'($urandom_range(0, 172800)) - 86400;
            if (at < 0) begin
              at = 0;
            end else if (at > 64'hFFFF_FFFF) begin
              at = 64'hFFFF_FFFF;
            end
            w = at[31:0];
          end
          default: begin
            w = $urandom;
          end
        endcase
        batch.push_back(w);
      end
      push_words(batch);
    end

    // Let every prediction come home, then give the verdict.
    settle();
    $display("Converted %0d timestamps under %0d offset settings; %0d results were clamped.",
             words_sent, settings_used, clamped_seen);
    $display("Input arrived in random bursts while the result side stalled in four patterns.");
    if (mismatches == 0 && pending == 0 && results_seen == words_sent) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ epoch_seconds_to_calendar.f @@
src/esc_pkg.sv
src/esc_if.sv
src/esc_ucode_rom.sv
src/esc_datapath.sv
src/esc_sequencer.sv
src/epoch_seconds_to_calendar.sv
verif/esc_checker.sv
verif/epoch_seconds_to_calendar_tb.sv
